>>> hdl/bsp_pkg.sv
package bsp_pkg;

  localparam int DIM_W       = 13;
  localparam int CNT_W       = 7;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_TDATA_W = 8;
  localparam int DIV_STEP_W  = 4;

  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } bsp_state_t;

endpackage

>>> hdl/bsp_div.sv
// Restoring divider, one quotient bit per cycle.
module bsp_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  bsp_pkg::dim_t dividend,
  input  bsp_pkg::cnt_t divisor,
  output logic          done,
  output bsp_pkg::dim_t quotient,
  output bsp_pkg::cnt_t remainder
);
  import bsp_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_STEP_W-1:0] step_r, step_nxt;
  dim_t                  quo_r, quo_nxt;
  cnt_t                  rem_r, rem_nxt;
  cnt_t                  dsr_r, dsr_nxt;
  logic [CNT_W:0]        trial;
  logic [CNT_W:0]        diff;

  always_comb begin
    trial    = {rem_r, quo_r[DIM_W-1]};
    diff     = trial - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // trial stays below twice the divisor, so it fits the remainder width
      rem_nxt  = diff[CNT_W] ? trial[CNT_W-1:0] : diff[CNT_W-1:0];
      quo_nxt  = {quo_r[DIM_W-2:0], ~diff[CNT_W]};
      step_nxt = step_r + 1'b1;
      if (step_r == DIV_STEP_W'(DIM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> hdl/balanced_strip_partitioner.sv
// Channel  Ports                       Beat
// -------  --------------------------  ---------------------------------------------
// in       in_tvalid/in_tready         one grid: height, width, segment count
// out      out_tvalid/out_tready       one strip's bounds; tlast on the last strip
// cfg      cfg_tvalid/cfg_tready       split_columns in bit 0, always ready
//
// An item is accepted, divided in the shared restoring divider (one quotient bit
// per step), handed over, then emitted one strip per cycle into the output register
// while out_tready does not stall it. A segment count of zero returns to idle at once.
// in_tready is high only when the sequencer is idle. A stalled out_tready holds
// the output register and pauses strip generation. Reset is synchronous, active low.
module balanced_strip_partitioner #(
  parameter int MAX_SEGMENTS = 64,
  parameter int MAX_DIM      = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // grid_height[12:0], grid_width[25:13], segment_count[32:26], zero pad
  input  logic [bsp_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // row_first[12:0], row_last[25:13], col_first[38:26], col_last[51:39], zero pad
  output logic [bsp_pkg::OUT_TDATA_W-1:0] out_tdata,
  // final_strip
  output logic                            out_tlast,
  input  logic                            cfg_tvalid,
  output logic                            cfg_tready,
  // split_columns[0], zero pad
  input  logic [bsp_pkg::CFG_TDATA_W-1:0] cfg_tdata
);
  import bsp_pkg::*;

  localparam logic [16:0] DIM_LIMIT = 17'(MAX_DIM);
  localparam cnt_t        SEG_LIMIT = CNT_W'(MAX_SEGMENTS);

  bsp_state_t state_r, state_nxt;
  logic       split_cols_r;

  dim_t h_r, h_nxt;
  dim_t w_r, w_nxt;
  cnt_t n_r, n_nxt;
  cnt_t k_r, k_nxt;
  dim_t start_r, start_nxt;
  dim_t prev_r, prev_nxt;
  logic ended_r, ended_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_last_r, out_last_nxt;
  dim_t rf_r, rf_nxt, rl_r, rl_nxt, cf_r, cf_nxt, cl_r, cl_nxt;

  dim_t in_h, in_w, sat_h, sat_w;
  cnt_t in_n, sat_n;

  logic div_start, div_done;
  dim_t div_q;
  cnt_t div_r;

  logic accept, fire, ended_now;
  dim_t next_start, strip_last;

  assign in_h  = in_tdata[DIM_W-1:0];
  assign in_w  = in_tdata[2*DIM_W-1:DIM_W];
  assign in_n  = in_tdata[2*DIM_W+CNT_W-1:2*DIM_W];
  assign sat_h = ({4'b0, in_h} > DIM_LIMIT) ? DIM_W'(MAX_DIM) : in_h;
  assign sat_w = ({4'b0, in_w} > DIM_LIMIT) ? DIM_W'(MAX_DIM) : in_w;
  assign sat_n = (in_n > SEG_LIMIT) ? SEG_LIMIT : in_n;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign div_start  = accept && (sat_n != '0);
  assign cfg_tready = 1'b1;

  bsp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (split_cols_r ? sat_w : sat_h),
    .divisor  (sat_n),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_r)
  );

  // strip k+1 starts q (+1 while k < r) past strip k
  assign next_start = start_r + div_q + DIM_W'(k_r < div_r);
  assign strip_last = next_start - 1'b1;
  assign ended_now  = (k_r != '0) && (ended_r || (start_r == prev_r));
  assign fire       = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    w_nxt         = w_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    start_nxt     = start_r;
    prev_nxt      = prev_r;
    ended_nxt     = ended_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    rf_nxt        = rf_r;
    rl_nxt        = rl_r;
    cf_nxt        = cf_r;
    cl_nxt        = cl_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          h_nxt = sat_h;
          w_nxt = sat_w;
          n_nxt = sat_n;
          if (sat_n != '0) state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          k_nxt     = '0;
          start_nxt = '0;
          prev_nxt  = '0;
          ended_nxt = 1'b0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (fire) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = (k_r == n_r - 1'b1);
          if (ended_now) begin
            rf_nxt = '1;
            rl_nxt = '1;
            cf_nxt = '1;
            cl_nxt = '1;
          end else if (split_cols_r) begin
            rf_nxt = '0;
            rl_nxt = h_r - 1'b1;
            cf_nxt = start_r;
            cl_nxt = strip_last;
          end else begin
            rf_nxt = start_r;
            rl_nxt = strip_last;
            cf_nxt = '0;
            cl_nxt = w_r - 1'b1;
          end
          ended_nxt = ended_now;
          prev_nxt  = start_r;
          start_nxt = next_start;
          k_nxt     = k_r + 1'b1;
          if (k_r == n_r - 1'b1) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      split_cols_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_tvalid && cfg_tready) split_cols_r <= cfg_tdata[0];
    end
    h_r        <= h_nxt;
    w_r        <= w_nxt;
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    start_r    <= start_nxt;
    prev_r     <= prev_nxt;
    ended_r    <= ended_nxt;
    out_last_r <= out_last_nxt;
    rf_r       <= rf_nxt;
    rl_r       <= rl_nxt;
    cf_r       <= cf_nxt;
    cl_r       <= cl_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0, cl_r, cf_r, rl_r, rf_r};

endmodule

>>> tb/balanced_strip_partitioner_test.sv
`timescale 1ns / 100ps

module balanced_strip_partitioner_test;
  import bsp_pkg::*;

  localparam int MAX_SEGMENTS = 64;
  localparam int MAX_DIM      = 4096;
  localparam int TAIL_CYCLES  = 100;  // room for the longest grid of 64 strips, with margin
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_GRIDS  = 45;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [DIM_W-1:0] row_first;
    logic [DIM_W-1:0] row_last;
    logic [DIM_W-1:0] col_first;
    logic [DIM_W-1:0] col_last;
    logic             final_strip;
  } strip_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_tvalid = 1'b0;
  logic                   cfg_tready;
  logic [CFG_TDATA_W-1:0] cfg_tdata = '0;

  logic [IN_TDATA_W-1:0] pending_grids[$];
  strip_t                expected_strips[$];

  bit split_mode;      // mirror of split_columns
  bit no_idle;
  bit hold_req;
  int in_gap;
  int out_stall;
  int hold_left;
  int mismatches;
  int orphans;
  int grids_sent;
  int strips_seen;
  int cfg_writes;
  int leftover;
  int failures;

  balanced_strip_partitioner #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .MAX_DIM     (MAX_DIM)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_tvalid(cfg_tvalid),
    .cfg_tready(cfg_tready),
    .cfg_tdata (cfg_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("balanced_strip_partitioner verification failed");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return DIM_W'($urandom_range(0, 40));
    if (r < 75) return DIM_W'($urandom_range(41, 300));
    if (r < 90) return DIM_W'($urandom_range(301, 4096));
    return DIM_W'($urandom_range(4097, 8191));
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return CNT_W'($urandom_range(65, 127));
    if (r < 70) return CNT_W'($urandom_range(1, 8));
    if (r < 90) return CNT_W'($urandom_range(9, 32));
    return CNT_W'($urandom_range(33, 64));
  endfunction

  task automatic queue_grid(input logic [DIM_W-1:0] h, input logic [DIM_W-1:0] w,
                            input logic [CNT_W-1:0] n);
    pending_grids.push_back({7'd0, n, w, h});
  endtask

  task automatic predict_strips(input logic [DIM_W-1:0] h_in, input logic [DIM_W-1:0] w_in,
                                input logic [CNT_W-1:0] n_in);
    int h, w, n, span, q, r, k, first, last, prev_first;
    bit ended;
    strip_t s;
    h = (h_in > MAX_DIM) ? MAX_DIM : h_in;
    w = (w_in > MAX_DIM) ? MAX_DIM : w_in;
    n = (n_in > MAX_SEGMENTS) ? MAX_SEGMENTS : n_in;
    if (n == 0) return;
    span = split_mode ? w : h;
    q = span / n;
    r = span % n;
    ended = 1'b0;
    prev_first = 0;
    for (k = 0; k < n; k++) begin
      first = k * q + ((k < r) ? k : r);
      last  = (k + 1) * q - 1 + ((k + 1 < r) ? k + 1 : r);
      // a repeated start means the dimension is used up from here on
      if (k > 0 && (ended || first == prev_first)) ended = 1'b1;
      prev_first = first;
      if (ended) begin
        s.row_first = '1;
        s.row_last  = '1;
        s.col_first = '1;
        s.col_last  = '1;
      end else if (split_mode) begin
        s.row_first = '0;
        s.row_last  = DIM_W'(h - 1);
        s.col_first = DIM_W'(first);
        s.col_last  = DIM_W'(last);
      end else begin
        s.row_first = DIM_W'(first);
        s.row_last  = DIM_W'(last);
        s.col_first = '0;
        s.col_last  = DIM_W'(w - 1);
      end
      s.final_strip = (k == n - 1);
      expected_strips.push_back(s);
    end
  endtask

  task automatic write_split(input bit val);
    @(posedge clk);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= {7'd0, val};
    do @(posedge clk); while (!(cfg_tvalid && cfg_tready));
    split_mode = cfg_tdata[0];
    cfg_writes++;
    cfg_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_grids.size() != 0 || in_tvalid || expected_strips.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic queue_directed();
    queue_grid(1, 1, 1);
    queue_grid(4096, 4096, 64);
    queue_grid(8191, 8191, 127);
    queue_grid(0, 0, 1);
    queue_grid(0, 5, 3);
    queue_grid(5, 0, 3);
    queue_grid(10, 10, 0);
    queue_grid(7, 9, 3);
    queue_grid(3, 3, 5);
    queue_grid(4096, 1, 64);
    queue_grid(100, 100, 65);
    queue_grid(4097, 4097, 7);
    queue_grid(1, 4096, 2);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_strips(in_tdata[12:0], in_tdata[25:13], in_tdata[32:26]);
        grids_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_grids.size() != 0) begin
          in_tdata  <= pending_grids.pop_front();
          in_tvalid <= 1'b1;
          in_gap = no_idle ? 0 : idle_len();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor and ready generator
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall = 0;
      hold_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        strips_seen++;
        if (expected_strips.size() == 0) begin
          orphans++;
          $display("unexpected strip beat: data=%h last=%b", out_tdata, out_tlast);
        end else begin
          strip_t exp_s;
          exp_s = expected_strips.pop_front();
          if (out_tdata[12:0] !== exp_s.row_first || out_tdata[25:13] !== exp_s.row_last ||
              out_tdata[38:26] !== exp_s.col_first || out_tdata[51:39] !== exp_s.col_last ||
              out_tlast !== exp_s.final_strip) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"strip mismatch: exp rows %0d..%0d cols %0d..%0d last %b,",
                        " got rows %0d..%0d cols %0d..%0d last %b"},
                       $signed(exp_s.row_first), $signed(exp_s.row_last),
                       $signed(exp_s.col_first), $signed(exp_s.col_last), exp_s.final_strip,
                       $signed(out_tdata[12:0]), $signed(out_tdata[25:13]),
                       $signed(out_tdata[38:26]), $signed(out_tdata[51:39]), out_tlast);
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) out_stall = idle_len();
      end
    end
  end

  initial begin
    int ph, i;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    write_split(1'b0);
    queue_directed();
    wait_drained();
    write_split(1'b1);
    queue_directed();
    wait_drained();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      write_split(1'(ph % 2));
      no_idle = (ph == 2);
      for (i = 0; i < PHASE_GRIDS; i++) queue_grid(pick_dim(), pick_dim(), pick_count());
      // long receiver hold-off while the sender keeps offering grids
      if (ph == 3) hold_req = 1'b1;
      wait_drained();
    end

    leftover = expected_strips.size();
    if (leftover != 0) $display("%0d expected strips never arrived", leftover);
    failures = mismatches + orphans + leftover;
    $display("covered %0d grids and %0d strip beats over %0d split settings",
             grids_sent, strips_seen, cfg_writes);
    $display("row and column splits, saturated sizes, zero sizes and exhausted strips included");
    if (failures == 0) begin
      $display("balanced_strip_partitioner verification clean");
    end else begin
      $display("balanced_strip_partitioner verification failed");
    end
    $finish;
  end

endmodule
